// ===== design/plc_io_board_register_map_core_macros.svh =====
// Assertion macros for the PLC I/O board register map.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef PLC_IO_BOARD_REGISTER_MAP_CORE_MACROS_SVH
`define PLC_IO_BOARD_REGISTER_MAP_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLC_IOB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plc_iob: implication check failed");

// Next-cycle implication, disabled during reset.
`define PLC_IOB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plc_iob: next-cycle check failed");

`endif

// ===== design/plc_iob_pkg.sv =====
// Shared constants, types and opcodes for the PLC I/O board register map.
// No dependencies; imported by the register, execute and top modules of the block.
package plc_iob_pkg;

  localparam int BOARDS            = 4;
  localparam int INPUTS_PER_BOARD  = 32;
  localparam int OUTPUTS_PER_BOARD = 16;

  localparam int OP_W    = 3;
  localparam int INDEX_W = 8;
  localparam int CNT_W   = 32;

  // Address decode: inputs take 64 channels per board, outputs 32.
  localparam int IN_STRIDE      = 64;
  localparam int OUT_STRIDE     = 32;
  localparam int IN_CHAN_W      = $clog2(IN_STRIDE);
  localparam int OUT_CHAN_W     = $clog2(OUT_STRIDE);
  localparam int IN_OVL_CHAN    = IN_STRIDE - 1;
  localparam int OUT_REARM_CHAN = OUT_STRIDE - 1;

  localparam int BOARD_W  = (BOARDS > 1) ? $clog2(BOARDS) : 1;
  localparam int IN_BIT_W = (INPUTS_PER_BOARD > 1) ? $clog2(INPUTS_PER_BOARD) : 1;
  localparam int OUT_BIT_W = (OUTPUTS_PER_BOARD > 1) ? $clog2(OUTPUTS_PER_BOARD) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_READ_IN   = 3'd0,
    OP_SET_IN    = 3'd1,
    OP_READ_OUT  = 3'd2,
    OP_WRITE_OUT = 3'd3,
    OP_SET_OVL   = 3'd4
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [INDEX_W-1:0] index;
    logic               value;
  } item_t;

  typedef struct packed {
    logic             bit_value;
    logic             board_valid;
    logic [CNT_W-1:0] input_read_count;
    logic [CNT_W-1:0] output_write_count;
    logic [CNT_W-1:0] overload_reset_count;
  } result_t;

endpackage

// ===== design/plc_iob_in_reg.sv =====
// Input register stage: captures one accepted beat and holds it until executed.
// Depends on plc_iob_pkg.
module plc_iob_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plc_iob_pkg::item_t  in_item,
  input  logic                pop,
  output logic                item_valid,
  output plc_iob_pkg::item_t  item
);
  import plc_iob_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // Take a new beat when empty or when the held one leaves this cycle.
  assign in_ready = !valid_r || pop;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== design/plc_iob_exec.sv =====
// Board state and single-pass operation logic: I/O bits, overload flags, counters.
// Depends on plc_iob_pkg; state advances only when fire is high.
module plc_iob_exec (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  plc_iob_pkg::item_t   item,
  output plc_iob_pkg::result_t result
);
  import plc_iob_pkg::*;

  logic [INPUTS_PER_BOARD-1:0]  in_bits_r  [BOARDS];
  logic [INPUTS_PER_BOARD-1:0]  in_bits_nxt [BOARDS];
  logic [OUTPUTS_PER_BOARD-1:0] out_bits_r  [BOARDS];
  logic [OUTPUTS_PER_BOARD-1:0] out_bits_nxt [BOARDS];
  logic [BOARDS-1:0]            ovl_ok_r, ovl_ok_nxt;
  logic [CNT_W-1:0]             rd_cnt_r    [BOARDS];
  logic [CNT_W-1:0]             rd_cnt_nxt  [BOARDS];
  logic [CNT_W-1:0]             wr_cnt_r    [BOARDS];
  logic [CNT_W-1:0]             wr_cnt_nxt  [BOARDS];
  logic [CNT_W-1:0]             rearm_cnt_r   [BOARDS];
  logic [CNT_W-1:0]             rearm_cnt_nxt [BOARDS];

  always_comb begin
    logic [INDEX_W-1:0]    in_brd;
    logic [INDEX_W-1:0]    out_brd;
    logic [INDEX_W-1:0]    brd;
    logic [IN_CHAN_W-1:0]  in_chan;
    logic [OUT_CHAN_W-1:0] out_chan;
    logic [BOARD_W-1:0]    bidx;
    logic                  brd_ok;
    logic                  bit_v;
    logic                  valid_v;

    in_brd   = INDEX_W'(item.index[INDEX_W-1:IN_CHAN_W]);
    out_brd  = INDEX_W'(item.index[INDEX_W-1:OUT_CHAN_W]);
    in_chan  = item.index[IN_CHAN_W-1:0];
    out_chan = item.index[OUT_CHAN_W-1:0];

    unique case (op_t'(item.operation))
      OP_READ_IN, OP_SET_IN:     brd = in_brd;
      OP_READ_OUT, OP_WRITE_OUT: brd = out_brd;
      default:                   brd = item.index;
    endcase
    brd_ok = (brd < INDEX_W'(BOARDS));
    bidx   = brd[BOARD_W-1:0];

    in_bits_nxt   = in_bits_r;
    out_bits_nxt  = out_bits_r;
    ovl_ok_nxt    = ovl_ok_r;
    rd_cnt_nxt    = rd_cnt_r;
    wr_cnt_nxt    = wr_cnt_r;
    rearm_cnt_nxt = rearm_cnt_r;
    bit_v         = 1'b0;
    valid_v       = 1'b0;

    if (brd_ok) begin
      unique case (op_t'(item.operation))
        OP_READ_IN: begin
          valid_v = 1'b1;
          rd_cnt_nxt[bidx] = rd_cnt_r[bidx] + CNT_W'(1);
          // Top channel of each input board reports overload-ok.
          if (in_chan == IN_CHAN_W'(IN_OVL_CHAN)) begin
            bit_v = ovl_ok_r[bidx];
          end else if (in_chan < IN_CHAN_W'(INPUTS_PER_BOARD)) begin
            bit_v = in_bits_r[bidx][in_chan[IN_BIT_W-1:0]];
          end
        end
        OP_SET_IN: begin
          valid_v = 1'b1;
          if (in_chan < IN_CHAN_W'(INPUTS_PER_BOARD)) begin
            in_bits_nxt[bidx][in_chan[IN_BIT_W-1:0]] = item.value;
          end
        end
        OP_READ_OUT: begin
          valid_v = 1'b1;
          if (out_chan < OUT_CHAN_W'(OUTPUTS_PER_BOARD)) begin
            bit_v = out_bits_r[bidx][out_chan[OUT_BIT_W-1:0]];
          end
        end
        OP_WRITE_OUT: begin
          valid_v = 1'b1;
          wr_cnt_nxt[bidx] = wr_cnt_r[bidx] + CNT_W'(1);
          // Top output channel re-arms overload-ok on a one; a zero only counts.
          if (out_chan == OUT_CHAN_W'(OUT_REARM_CHAN)) begin
            if (item.value) begin
              ovl_ok_nxt[bidx]    = 1'b1;
              rearm_cnt_nxt[bidx] = rearm_cnt_r[bidx] + CNT_W'(1);
            end
          end else if (out_chan < OUT_CHAN_W'(OUTPUTS_PER_BOARD)) begin
            out_bits_nxt[bidx][out_chan[OUT_BIT_W-1:0]] = item.value;
          end
        end
        OP_SET_OVL: begin
          valid_v = 1'b1;
          ovl_ok_nxt[bidx] = !item.value;
        end
        default: begin
          valid_v = 1'b0;
        end
      endcase
    end

    result.bit_value   = bit_v;
    result.board_valid = valid_v;
    if (valid_v) begin
      result.input_read_count     = rd_cnt_nxt[bidx];
      result.output_write_count   = wr_cnt_nxt[bidx];
      result.overload_reset_count = rearm_cnt_nxt[bidx];
    end else begin
      result.input_read_count     = '0;
      result.output_write_count   = '0;
      result.overload_reset_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovl_ok_r <= '1;
      for (int b = 0; b < BOARDS; b++) begin
        in_bits_r[b]   <= '0;
        out_bits_r[b]  <= '0;
        rd_cnt_r[b]    <= '0;
        wr_cnt_r[b]    <= '0;
        rearm_cnt_r[b] <= '0;
      end
    end else if (fire) begin
      ovl_ok_r    <= ovl_ok_nxt;
      in_bits_r   <= in_bits_nxt;
      out_bits_r  <= out_bits_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      wr_cnt_r    <= wr_cnt_nxt;
      rearm_cnt_r <= rearm_cnt_nxt;
    end
  end

endmodule

// ===== design/plc_iob_out_reg.sv =====
// Result register: holds one finished beat until the consumer takes it.
// Depends on plc_iob_pkg.
module plc_iob_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  output logic                 res_ready,
  input  plc_iob_pkg::result_t res,
  output logic                 out_valid,
  input  logic                 out_ready,
  output plc_iob_pkg::result_t out_res
);
  import plc_iob_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;
  logic    load;

  assign res_ready = !valid_r || out_ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== design/plc_io_board_register_map_core.sv =====
// PLC I/O board register map: one bus operation per beat (read or set an input bit,
// read or write an output bit, set overload) with per-board read, write and re-arm
// counters. Throughput is one beat per clock while the consumer is ready. A result is
// presented from the result register: the input register captures the beat, and the
// result register takes the single pass of decode and state update once it can accept
// it. Input and output both stall cleanly.
module plc_io_board_register_map_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [plc_iob_pkg::OP_W-1:0]    in_operation,
  input  logic [plc_iob_pkg::INDEX_W-1:0] in_index,
  input  logic                            in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_bit_value,
  output logic                            out_board_valid,
  output logic [plc_iob_pkg::CNT_W-1:0]   out_input_read_count,
  output logic [plc_iob_pkg::CNT_W-1:0]   out_output_write_count,
  output logic [plc_iob_pkg::CNT_W-1:0]   out_overload_reset_count
);
  import plc_iob_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    res_ready;
  logic    fire;
  result_t res;
  result_t out_res;

  assign in_item.operation = in_operation;
  assign in_item.index     = in_index;
  assign in_item.value     = in_value;

  // Execute the held beat when the result register can take it.
  assign fire = item_valid && res_ready;

  plc_iob_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .pop        (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  plc_iob_exec u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (res)
  );

  plc_iob_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_bit_value            = out_res.bit_value;
  assign out_board_valid          = out_res.board_valid;
  assign out_input_read_count     = out_res.input_read_count;
  assign out_output_write_count   = out_res.output_write_count;
  assign out_overload_reset_count = out_res.overload_reset_count;

endmodule

// ===== design/plc_iob_checker.sv =====
// Port-level checker for the PLC I/O board register map, bound to the top level.
// Depends on plc_io_board_register_map_core_macros.svh.
`include "plc_io_board_register_map_core_macros.svh"

module plc_iob_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_bit_value,
  input logic        out_board_valid,
  input logic [31:0] out_input_read_count,
  input logic [31:0] out_output_write_count,
  input logic [31:0] out_overload_reset_count
);

  logic        zero_beat;
  logic [97:0] out_beat;

  assign zero_beat = !out_bit_value && (out_input_read_count == 32'd0) &&
                     (out_output_write_count == 32'd0) &&
                     (out_overload_reset_count == 32'd0);
  assign out_beat  = {out_bit_value, out_board_valid, out_input_read_count,
                      out_output_write_count, out_overload_reset_count};

  // An invalid board returns an all-zero beat.
  `PLC_IOB_ASSERT_IMP(a_invalid_zero, out_valid && !out_board_valid, zero_beat)

  // A ready consumer never backpressures the input.
  `PLC_IOB_ASSERT_IMP(a_ready_through, out_ready, in_ready)

  // An accepted beat followed by a ready consumer yields a result.
  `PLC_IOB_ASSERT_NXT(a_latency, (in_valid && in_ready) ##1 out_ready, out_valid)

  // Hold a stalled result.
  `PLC_IOB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))

endmodule

bind plc_io_board_register_map_core plc_iob_checker u_plc_iob_checker (.*);

// ===== tb/plc_iob_scoreboard.sv =====
// Scoreboard for the PLC I/O board register map: mirrors the board state,
// predicts one reply per accepted bus beat and compares replies in order.
// Depends on plc_iob_pkg for widths, opcodes and the reply struct.
module plc_iob_scoreboard (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [plc_iob_pkg::OP_W-1:0]    in_operation,
  input  logic [plc_iob_pkg::INDEX_W-1:0] in_index,
  input  logic                            in_value,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_bit_value,
  input  logic                            out_board_valid,
  input  logic [plc_iob_pkg::CNT_W-1:0]   out_input_read_count,
  input  logic [plc_iob_pkg::CNT_W-1:0]   out_output_write_count,
  input  logic [plc_iob_pkg::CNT_W-1:0]   out_overload_reset_count,
  output int unsigned                     mismatches,
  output int unsigned                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import plc_iob_pkg::*;

  logic             in_bits   [BOARDS][INPUTS_PER_BOARD];
  logic             out_bits  [BOARDS][OUTPUTS_PER_BOARD];
  logic             ovl_ok    [BOARDS];
  logic [CNT_W-1:0] in_reads  [BOARDS];
  logic [CNT_W-1:0] out_writes[BOARDS];
  logic [CNT_W-1:0] rearms    [BOARDS];

  result_t bus_replies_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Apply one bus access to the mirrored boards and return its reply.
  function automatic result_t predict_access(input logic [OP_W-1:0] op,
                                             input logic [INDEX_W-1:0] idx,
                                             input logic val);
    result_t     r;
    int unsigned brd;
    int unsigned ch;
    logic        hit;
    r   = '0;
    hit = 1'b0;
    brd = 0;
    ch  = 0;
    case (op)
      OP_READ_IN: begin
        brd = idx / IN_STRIDE;
        ch  = idx % IN_STRIDE;
        if (brd < BOARDS) begin
          hit = 1'b1;
          in_reads[brd] = in_reads[brd] + 1'b1;
          if (ch == IN_OVL_CHAN) r.bit_value = ovl_ok[brd];
          else if (ch < INPUTS_PER_BOARD) r.bit_value = in_bits[brd][ch];
        end
      end
      OP_SET_IN: begin
        brd = idx / IN_STRIDE;
        ch  = idx % IN_STRIDE;
        if (brd < BOARDS) begin
          hit = 1'b1;
          if (ch < INPUTS_PER_BOARD) in_bits[brd][ch] = val;
        end
      end
      OP_READ_OUT: begin
        brd = idx / OUT_STRIDE;
        ch  = idx % OUT_STRIDE;
        if (brd < BOARDS) begin
          hit = 1'b1;
          if (ch < OUTPUTS_PER_BOARD) r.bit_value = out_bits[brd][ch];
        end
      end
      OP_WRITE_OUT: begin
        brd = idx / OUT_STRIDE;
        ch  = idx % OUT_STRIDE;
        if (brd < BOARDS) begin
          hit = 1'b1;
          out_writes[brd] = out_writes[brd] + 1'b1;
          if (ch == OUT_REARM_CHAN) begin
            if (val) begin
              ovl_ok[brd] = 1'b1;
              rearms[brd] = rearms[brd] + 1'b1;
            end
          end else if (ch < OUTPUTS_PER_BOARD) begin
            out_bits[brd][ch] = val;
          end
        end
      end
      OP_SET_OVL: begin
        brd = idx;
        if (brd < BOARDS) begin
          hit = 1'b1;
          ovl_ok[brd] = ~val;
        end
      end
      default: ;
    endcase
    if (hit) begin
      r.board_valid          = 1'b1;
      r.input_read_count     = in_reads[brd];
      r.output_write_count   = out_writes[brd];
      r.overload_reset_count = rearms[brd];
    end else begin
      r = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      for (int b = 0; b < BOARDS; b++) begin
        for (int c = 0; c < INPUTS_PER_BOARD; c++) in_bits[b][c] = 1'b0;
        for (int c = 0; c < OUTPUTS_PER_BOARD; c++) out_bits[b][c] = 1'b0;
        ovl_ok[b]     = 1'b1;
        in_reads[b]   = '0;
        out_writes[b] = '0;
        rearms[b]     = '0;
      end
      bus_replies_q.delete();
      outstanding <= 0;
    end else begin
      if (in_valid && in_ready)
        bus_replies_q.push_back(predict_access(in_operation, in_index, in_value));
      if (out_valid && out_ready) begin
        if (bus_replies_q.size() == 0) begin
          $display("%0t ns: reply beat with no access outstanding", $time);
          mismatches++;
        end else begin
          want = bus_replies_q.pop_front();
          check_field("bit_value", want.bit_value, out_bit_value);
          check_field("board_valid", want.board_valid, out_board_valid);
          check_field("input_read_count", want.input_read_count, out_input_read_count);
          check_field("output_write_count", want.output_write_count,
                      out_output_write_count);
          check_field("overload_reset_count", want.overload_reset_count,
                      out_overload_reset_count);
        end
      end
      outstanding <= bus_replies_q.size();
    end
  end

endmodule

// ===== tb/tb_plc_io_board_register_map_core.sv =====
// Testbench top for plc_io_board_register_map_core: clock, reset, bus stimulus
// and reply back-pressure; checking is done by plc_iob_scoreboard.
// Depends on plc_iob_pkg, the core RTL and tb/plc_iob_scoreboard.sv.
module tb_plc_io_board_register_map_core;
  timeunit 1ns;
  timeprecision 1ps;

  import plc_iob_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          PHASE_BEATS = 137;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [OP_W-1:0]    in_operation;
  logic [INDEX_W-1:0] in_index;
  logic               in_value;
  logic               out_valid;
  logic               out_ready;
  logic               out_bit_value;
  logic               out_board_valid;
  logic [CNT_W-1:0]   out_input_read_count;
  logic [CNT_W-1:0]   out_output_write_count;
  logic [CNT_W-1:0]   out_overload_reset_count;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned cycles;

  plc_io_board_register_map_core i_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_operation             (in_operation),
    .in_index                 (in_index),
    .in_value                 (in_value),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_bit_value            (out_bit_value),
    .out_board_valid          (out_board_valid),
    .out_input_read_count     (out_input_read_count),
    .out_output_write_count   (out_output_write_count),
    .out_overload_reset_count (out_overload_reset_count)
  );

  plc_iob_scoreboard i_scoreboard (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_operation             (in_operation),
    .in_index                 (in_index),
    .in_value                 (in_value),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_bit_value            (out_bit_value),
    .out_board_valid          (out_board_valid),
    .out_input_read_count     (out_input_read_count),
    .out_output_write_count   (out_output_write_count),
    .out_overload_reset_count (out_overload_reset_count),
    .mismatches               (mismatches),
    .outstanding              (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles        = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    out_ready    <= 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one bus beat, with a random idle gap ahead of it, and hold it until taken.
  task automatic issue(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                       input logic val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_index     <= idx;
    in_value     <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the bus until every reply has come back.
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic random_access();
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] idx;
    int unsigned        brd;
    int unsigned        pick;
    int unsigned        shape;
    brd   = $urandom_range(BOARDS - 1);
    pick  = $urandom_range(99);
    shape = $urandom_range(99);
    if (pick < 20) op = OP_READ_IN;
    else if (pick < 35) op = OP_SET_IN;
    else if (pick < 55) op = OP_READ_OUT;
    else if (pick < 80) op = OP_WRITE_OUT;
    else if (pick < 93) op = OP_SET_OVL;
    else begin
      case ($urandom_range(2))
        0:       op = OP_RSVD_5;
        1:       op = OP_RSVD_6;
        default: op = OP_RSVD_7;
      endcase
    end
    case (op)
      OP_READ_IN, OP_SET_IN: begin
        // Keep most accesses on a few channels so reads see earlier sets.
        if (shape < 50) idx = INDEX_W'(brd * IN_STRIDE + $urandom_range(7));
        else if (shape < 60) idx = INDEX_W'(brd * IN_STRIDE + IN_OVL_CHAN);
        else idx = INDEX_W'($urandom_range(255));
      end
      OP_READ_OUT, OP_WRITE_OUT: begin
        if (shape < 50) idx = INDEX_W'(brd * OUT_STRIDE + $urandom_range(5));
        else if (shape < 62) idx = INDEX_W'(brd * OUT_STRIDE + OUT_REARM_CHAN);
        else idx = INDEX_W'($urandom_range(255));
      end
      OP_SET_OVL: begin
        if (shape < 80) idx = INDEX_W'(brd);
        else idx = INDEX_W'($urandom_range(255));
      end
      default: idx = INDEX_W'($urandom_range(255));
    endcase
    issue(op, idx, 1'($urandom_range(1)));
  endtask

  initial begin : stimulus
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_READ_IN;
    in_index     <= '0;
    in_value     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: decode edges, overload flag paths, invalid boards, reserved opcodes.
    issue(OP_READ_IN,   8'd0,   1'b0);
    issue(OP_READ_IN,   8'd63,  1'b0);
    issue(OP_SET_IN,    8'd31,  1'b1);
    issue(OP_READ_IN,   8'd31,  1'b0);
    issue(OP_SET_IN,    8'd32,  1'b1);
    issue(OP_READ_IN,   8'd32,  1'b0);
    issue(OP_SET_IN,    8'd255, 1'b1);
    issue(OP_READ_IN,   8'd255, 1'b0);
    issue(OP_SET_OVL,   8'd3,   1'b1);
    issue(OP_READ_IN,   8'd255, 1'b0);
    issue(OP_WRITE_OUT, 8'd127, 1'b0);
    issue(OP_READ_IN,   8'd255, 1'b0);
    issue(OP_WRITE_OUT, 8'd127, 1'b1);
    issue(OP_READ_IN,   8'd255, 1'b0);
    issue(OP_WRITE_OUT, 8'd15,  1'b1);
    issue(OP_READ_OUT,  8'd15,  1'b0);
    issue(OP_WRITE_OUT, 8'd16,  1'b1);
    issue(OP_READ_OUT,  8'd16,  1'b0);
    issue(OP_READ_OUT,  8'd255, 1'b0);
    issue(OP_WRITE_OUT, 8'd128, 1'b1);
    issue(OP_SET_OVL,   8'd4,   1'b1);
    issue(OP_SET_OVL,   8'd255, 1'b1);
    issue(OP_RSVD_5,    8'd0,   1'b0);
    issue(OP_RSVD_6,    8'd64,  1'b1);
    issue(OP_RSVD_7,    8'd255, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      drain_replies();
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      repeat (PHASE_BEATS) random_access();
    end

    drain_replies();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/plc_iob_pkg.sv
design/plc_iob_in_reg.sv
design/plc_iob_exec.sv
design/plc_iob_out_reg.sv
design/plc_io_board_register_map_core.sv
design/plc_iob_checker.sv
tb/plc_iob_scoreboard.sv
tb/tb_plc_io_board_register_map_core.sv
